FILE: hdl/slc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_pkg
// Shared types and constants for the sequence line checker.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int LINE_LEN_DEF   = 80;

    localparam int CHAR_W   = 8;
    localparam int COLUMN_W = 7;
    localparam int OUT_CNT_W = 32;

    localparam int END_DIGIT_COL = 8;
    localparam int SEP_LAST_COL  = 75;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_C  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LO_G  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_LO_T  = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;

    typedef enum logic {
        ERR_SEPARATOR = 1'b0,
        ERR_FORMAT    = 1'b1
    } t_err_kind;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_A,
        CLS_C,
        CLS_G,
        CLS_T,
        CLS_OTHER
    } t_base_cls;

    // per-character result from the format checker
    typedef struct packed {
        logic                base_valid;
        logic [CHAR_W-1:0]   base;
        logic                error;
        t_err_kind           error_kind;
        logic [COLUMN_W-1:0] column;
        t_base_cls           cls;
    } t_chk_res;

endpackage

FILE: hdl/slc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_in_if / slc_out_if
// Valid/ready stream channels for characters and per-character results.
// ----------------------------------------------------------------------------
interface slc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_end;
    logic       start_sequence;

    modport source (output valid, output ch, output line_end, output start_sequence,
                    input ready);
    modport sink   (input valid, input ch, input line_end, input start_sequence,
                    output ready);
endinterface

interface slc_out_if;
    logic        valid;
    logic        ready;
    logic        base_valid;
    logic [7:0]  base;
    logic        error;
    logic        error_kind;
    logic [6:0]  column;
    logic [31:0] count_a;
    logic [31:0] count_c;
    logic [31:0] count_g;
    logic [31:0] count_t;
    logic [31:0] count_other;
    logic [31:0] count_total;

    modport source (output valid, output base_valid, output base, output error,
                    output error_kind, output column, output count_a, output count_c,
                    output count_g, output count_t, output count_other,
                    output count_total, input ready);
    modport sink   (input valid, input base_valid, input base, input error,
                    input error_kind, input column, input count_a, input count_c,
                    input count_g, input count_t, input count_other,
                    input count_total, output ready);
endinterface

FILE: hdl/slc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_checker
// Column tracking and format check of one character per transfer.
// ----------------------------------------------------------------------------
module slc_checker #(
    parameter int LINE_LEN = slc_pkg::LINE_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [slc_pkg::CHAR_W-1:0]  i_ch,
    input  logic                        i_line_end,
    output slc_pkg::t_chk_res           o_res
);
    import slc_pkg::*;

    localparam int COL_W = $clog2(LINE_LEN);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_LEN - 1);
    localparam logic [COL_W-1:0] COL_END_DIGIT = COL_W'(END_DIGIT_COL);
    localparam logic [COL_W-1:0] COL_SEP_LAST  = COL_W'(SEP_LAST_COL);

    logic [COL_W-1:0] r_col, n_col;
    logic             r_must_end, n_must_end;
    logic             r_aborted, n_aborted;

    logic              is_sep;
    logic              is_blank;
    logic              is_digit;
    logic [CHAR_W-1:0] lc;
    logic              is_letter;

    assign is_sep = (r_col == COL_W'(9))  || (r_col == COL_W'(20)) ||
                    (r_col == COL_W'(31)) || (r_col == COL_W'(42)) ||
                    (r_col == COL_W'(53)) || (r_col == COL_W'(64)) ||
                    (r_col == COL_SEP_LAST);
    assign is_blank  = (i_ch == CH_BLANK);
    assign is_digit  = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign lc        = ((i_ch >= CH_UP_A) && (i_ch <= CH_UP_Z)) ? (i_ch | CASE_BIT) : i_ch;
    assign is_letter = (lc >= CH_LO_A) && (lc <= CH_LO_Z);

    always_comb begin
        o_res            = '0;
        o_res.error_kind = ERR_SEPARATOR;
        o_res.cls        = CLS_NONE;
        o_res.column     = COLUMN_W'(r_col);
        n_must_end       = r_must_end;
        n_aborted        = r_aborted;

        if (!r_aborted) begin
            if (is_blank) begin
                if ((!is_sep || r_col == COL_SEP_LAST) &&
                    (r_col >= COL_SEP_LAST || r_col == COL_END_DIGIT)) begin
                    n_must_end = 1'b1;
                end
            end else if (is_sep) begin
                o_res.error      = 1'b1;
                o_res.error_kind = ERR_SEPARATOR;
            end else if (r_col <= COL_END_DIGIT) begin
                if (!is_digit) begin
                    o_res.error      = 1'b1;
                    o_res.error_kind = ERR_FORMAT;
                end
            end else if (r_must_end) begin
                o_res.error      = 1'b1;
                o_res.error_kind = ERR_FORMAT;
            end else if (is_letter) begin
                o_res.base_valid = 1'b1;
                o_res.base       = lc;
                case (lc)
                    CH_LO_A: o_res.cls = CLS_A;
                    CH_LO_C: o_res.cls = CLS_C;
                    CH_LO_G: o_res.cls = CLS_G;
                    CH_LO_T: o_res.cls = CLS_T;
                    default: o_res.cls = CLS_OTHER;
                endcase
            end
            if (o_res.error) begin
                n_aborted = 1'b1;
            end
        end

        // line end wins over everything that happened on the line
        if (i_line_end) begin
            n_col      = '0;
            n_must_end = 1'b0;
            n_aborted  = 1'b0;
        end else if (r_col < COL_MAX) begin
            n_col = r_col + 1'b1;
        end else begin
            n_col = r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_must_end <= 1'b0;
            r_aborted  <= 1'b0;
        end else if (i_accept) begin
            r_col      <= n_col;
            r_must_end <= n_must_end;
            r_aborted  <= n_aborted;
        end
    end

endmodule

FILE: hdl/slc_counters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slc_counters
// Saturating base counters with clear at sequence start.
// ----------------------------------------------------------------------------
module slc_counters #(
    parameter int COUNT_BITS = slc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_clear,
    input  slc_pkg::t_base_cls            i_cls,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_a,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_c,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_g,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_t,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_other,
    output logic [slc_pkg::OUT_CNT_W-1:0] o_cnt_total
);
    import slc_pkg::*;

    localparam int NUM_CNT = 6;
    localparam int IDX_A = 0, IDX_C = 1, IDX_G = 2, IDX_T = 3, IDX_OTHER = 4, IDX_TOTAL = 5;

    logic [COUNT_BITS-1:0] r_cnt [NUM_CNT];
    logic [COUNT_BITS-1:0] n_cnt [NUM_CNT];
    logic [NUM_CNT-1:0]    bump;

    always_comb begin
        bump            = '0;
        bump[IDX_TOTAL] = (i_cls != CLS_NONE);
        case (i_cls)
            CLS_A:     bump[IDX_A]     = 1'b1;
            CLS_C:     bump[IDX_C]     = 1'b1;
            CLS_G:     bump[IDX_G]     = 1'b1;
            CLS_T:     bump[IDX_T]     = 1'b1;
            CLS_OTHER: bump[IDX_OTHER] = 1'b1;
            default:   bump            = '0;
        endcase
    end

    for (genvar k = 0; k < NUM_CNT; k++) begin : g_cnt
        logic [COUNT_BITS-1:0] base_val;
        assign base_val = i_clear ? '0 : r_cnt[k];
        assign n_cnt[k] = (bump[k] && (base_val != '1)) ? base_val + 1'b1 : base_val;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cnt[k] <= '0;
            end else if (i_accept) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // values after this character
    assign o_cnt_a     = OUT_CNT_W'(n_cnt[IDX_A]);
    assign o_cnt_c     = OUT_CNT_W'(n_cnt[IDX_C]);
    assign o_cnt_g     = OUT_CNT_W'(n_cnt[IDX_G]);
    assign o_cnt_t     = OUT_CNT_W'(n_cnt[IDX_T]);
    assign o_cnt_other = OUT_CNT_W'(n_cnt[IDX_OTHER]);
    assign o_cnt_total = OUT_CNT_W'(n_cnt[IDX_TOTAL]);

endmodule

FILE: hdl/sequence_line_checker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_line_checker_core
// Sequence line format checker and base counter, one character per transfer.
// Output: the result is registered and valid in the cycle after the input transfer.
// Throughput: one character per cycle; the output register refills in the
// same cycle its result is taken, so only a stalled sink holds the input.
// Reset: synchronous, clears column, line flags, base counters and the
// output valid.
// ----------------------------------------------------------------------------
module sequence_line_checker_core #(
    parameter int COUNT_BITS = slc_pkg::COUNT_BITS_DEF,
    parameter int LINE_LEN   = slc_pkg::LINE_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    slc_in_if.sink    i_in,
    slc_out_if.source o_out
);
    import slc_pkg::*;

    logic     accept;
    t_chk_res chk;
    logic [OUT_CNT_W-1:0] cnt_a, cnt_c, cnt_g, cnt_t, cnt_other, cnt_total;

    logic                 r_out_valid;
    t_chk_res             r_res;
    logic [OUT_CNT_W-1:0] r_cnt_a, r_cnt_c, r_cnt_g, r_cnt_t, r_cnt_other, r_cnt_total;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    slc_checker #(
        .LINE_LEN (LINE_LEN)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_ch       (i_in.ch),
        .i_line_end (i_in.line_end),
        .o_res      (chk)
    );

    slc_counters #(
        .COUNT_BITS (COUNT_BITS)
    ) u_counters (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_clear     (i_in.start_sequence),
        .i_cls       (chk.cls),
        .o_cnt_a     (cnt_a),
        .o_cnt_c     (cnt_c),
        .o_cnt_g     (cnt_g),
        .o_cnt_t     (cnt_t),
        .o_cnt_other (cnt_other),
        .o_cnt_total (cnt_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res       <= chk;
            r_cnt_a     <= cnt_a;
            r_cnt_c     <= cnt_c;
            r_cnt_g     <= cnt_g;
            r_cnt_t     <= cnt_t;
            r_cnt_other <= cnt_other;
            r_cnt_total <= cnt_total;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.base_valid  = r_res.base_valid;
    assign o_out.base        = r_res.base;
    assign o_out.error       = r_res.error;
    assign o_out.error_kind  = r_res.error_kind;
    assign o_out.column      = r_res.column;
    assign o_out.count_a     = r_cnt_a;
    assign o_out.count_c     = r_cnt_c;
    assign o_out.count_g     = r_cnt_g;
    assign o_out.count_t     = r_cnt_t;
    assign o_out.count_other = r_cnt_other;
    assign o_out.count_total = r_cnt_total;

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sequence_line_checker_core. Sends sequence-line
// characters over the input channel and predicts each per-character result:
// column, format errors, accepted base and saturating counts. Every result
// is compared field by field. The run covers short directed lines, random
// well-formed and broken lines under several source/sink stall patterns,
// and a few full-width lines with a fixed base mix.
// ----------------------------------------------------------------------------
module tb_top;
    import slc_pkg::*;

    // counter width narrower than the block's default
    localparam int CNT_BITS    = 16;
    localparam int LINE_LEN    = LINE_LEN_DEF;
    localparam int N_TALLY     = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_GAP     = 40;
    localparam int LONG_LINES  = 2;

    typedef enum int {TL_A, TL_C, TL_G, TL_T, TL_OTHER, TL_TOTAL} t_tally;
    typedef enum int {FLOW_STEADY, FLOW_SRC_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} t_flow;

    typedef struct {
        logic                                base_valid;
        logic [CHAR_W-1:0]                   base;
        logic                                error;
        t_err_kind                           error_kind;
        logic [COLUMN_W-1:0]                 column;
        logic [N_TALLY-1:0][OUT_CNT_W-1:0]   count;
    } t_char_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    slc_in_if  in_ch();
    slc_out_if out_ch();

    sequence_line_checker_core #(
        .COUNT_BITS(CNT_BITS),
        .LINE_LEN  (LINE_LEN)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 clk = ~clk;

    // line and counter state as the block should hold it
    logic [COLUMN_W-1:0] line_col = '0;
    bit                  end_seen  = 1'b0;
    bit                  line_dead = 1'b0;
    logic [CNT_BITS-1:0] tally [N_TALLY] = '{default: '0};

    t_char_result pending_q [$];
    int           fail_count   = 0;
    int           live_chars   = 0;
    int           stall_cycles = 0;
    t_flow        flow         = FLOW_STEADY;
    string        tally_name [N_TALLY] = '{"count_a", "count_c", "count_g", "count_t",
                                           "count_other", "count_total"};

    function automatic bit is_sep_col(logic [COLUMN_W-1:0] col);
        return col inside {7'd9, 7'd20, 7'd31, 7'd42, 7'd53, 7'd64, 7'(SEP_LAST_COL)};
    endfunction

    function automatic logic [CNT_BITS-1:0] sat_inc(logic [CNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_seq_char();
        string bases;
        int    pick;
        bases = "acgtACGT";
        pick  = $urandom_range(99);
        if (pick < 80)
            return bases[$urandom_range(7)];
        if (pick < 90)
            return 8'(($urandom_range(1) ? CH_UP_A : CH_LO_A) + $urandom_range(25));
        return 8'($urandom_range(255));
    endfunction

    // advance the line state by one character and return its result
    function automatic t_char_result predict_char(logic [CHAR_W-1:0] c, bit last, bit start);
        t_char_result      r;
        logic [CHAR_W-1:0] lc;
        t_tally            cls;
        r.base_valid = 1'b0;
        r.base       = '0;
        r.error      = 1'b0;
        r.error_kind = ERR_SEPARATOR;
        r.column     = line_col;
        if (start)
            foreach (tally[i]) tally[i] = '0;
        if (!line_dead) begin
            if (c == CH_BLANK) begin
                // blank in the number's last column or past the last group ends the line
                if (line_col >= SEP_LAST_COL || line_col == END_DIGIT_COL)
                    end_seen = 1'b1;
            end else if (is_sep_col(line_col)) begin
                r.error      = 1'b1;
                r.error_kind = ERR_SEPARATOR;
            end else if (line_col <= END_DIGIT_COL) begin
                if (c < CH_ZERO || c > CH_NINE) begin
                    r.error      = 1'b1;
                    r.error_kind = ERR_FORMAT;
                end
            end else if (end_seen) begin
                r.error      = 1'b1;
                r.error_kind = ERR_FORMAT;
            end else begin
                lc = (c >= CH_UP_A && c <= CH_UP_Z) ? (c | CASE_BIT) : c;
                if (lc >= CH_LO_A && lc <= CH_LO_Z) begin
                    r.base_valid = 1'b1;
                    r.base       = lc;
                    case (lc)
                        CH_LO_A: cls = TL_A;
                        CH_LO_C: cls = TL_C;
                        CH_LO_G: cls = TL_G;
                        CH_LO_T: cls = TL_T;
                        default: cls = TL_OTHER;
                    endcase
                    tally[cls]      = sat_inc(tally[cls]);
                    tally[TL_TOTAL] = sat_inc(tally[TL_TOTAL]);
                end
            end
            line_dead = r.error;
        end
        foreach (tally[i]) r.count[i] = OUT_CNT_W'(tally[i]);
        if (last) begin
            line_col  = '0;
            end_seen  = 1'b0;
            line_dead = 1'b0;
        end else if (line_col < LINE_LEN - 1) begin
            line_col = line_col + 1'b1;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // result checker and stall watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_char_result got;
        t_char_result want;
        bit           moved;
        moved = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved          = 1'b1;
                got.base_valid = out_ch.base_valid;
                got.base       = out_ch.base;
                got.error      = out_ch.error;
                got.error_kind = t_err_kind'(out_ch.error_kind);
                got.column     = out_ch.column;
                got.count      = {out_ch.count_total, out_ch.count_other, out_ch.count_t,
                                  out_ch.count_g, out_ch.count_c, out_ch.count_a};
                if (pending_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no character pending, column %0d",
                             $time, got.column);
                end else begin
                    want = pending_q.pop_front();
                    check_field("base_valid", want.base_valid, got.base_valid);
                    check_field("base", want.base, got.base);
                    check_field("error", want.error, got.error);
                    check_field("error_kind", want.error_kind, got.error_kind);
                    check_field("column", want.column, got.column);
                    for (int i = 0; i < N_TALLY; i++)
                        check_field(tally_name[i], want.count[i], got.count[i]);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                if (!line_dead)
                    live_chars++;
                pending_q.insert(pending_q.size(),
                                 predict_char(in_ch.ch, in_ch.line_end,
                                              in_ch.start_sequence));
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // sink side: ready pattern follows the current flow
    always @(negedge clk) begin
        case (flow)
            FLOW_SINK_STALLS: out_ch.ready <= ($urandom_range(99) >= 73);
            FLOW_BOTH:        out_ch.ready <= ($urandom_range(99) >= 7);
            default:          out_ch.ready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------
    task automatic send_char(logic [CHAR_W-1:0] c, bit last, bit start);
        int gap;
        int pct;
        gap = 0;
        pct = (flow == FLOW_SRC_GAPS) ? 73 : (flow == FLOW_BOTH) ? 7 : 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.ch             <= c;
        in_ch.line_end       <= last;
        in_ch.start_sequence <= start;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_line(logic [CHAR_W-1:0] q [$], bit start_first, int start_pct);
        foreach (q[i])
            send_char(q[i], i == q.size() - 1,
                      (i == 0 && start_first) || $urandom_range(99) < start_pct);
    endtask

    // always waits on the clock before checking the queue, so valid is never driven twice at once
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [CHAR_W-1:0] q [$];
        flow = FLOW_STEADY;
        // bad number character aborts the line; the rest is ignored
        q = '{8'h00, "A"};
        send_line(q, 1'b1, 0);
        // number with blanks inside, mixed case, other letter, skipped bytes,
        // then a non-blank separator column
        q = '{"9", " ", " ", " ", " ", " ", " ", " ", "1", " ",
              "A", "c", "G", "t", "n", "-", 8'hFF, "z", "a", "T", "x", "g"};
        send_line(q, 1'b1, 0);
    endtask

    task automatic test_random(t_flow mode, int quota, bit clear_first);
        logic [CHAR_W-1:0] q [$];
        int                goal;
        int                n_digits;
        int                last_col;
        int                len;
        int                pick;
        bit                first;
        flow  = mode;
        goal  = live_chars + quota;
        first = clear_first;
        while (live_chars < goal) begin
            q.delete();
            if ($urandom_range(99) < 75) begin
                // mostly well-formed line with random content; some get a bad byte
                n_digits = $urandom_range(1, 9);
                for (int col = 0; col <= END_DIGIT_COL; col++)
                    q.insert(q.size(), col < 9 - n_digits ? CH_BLANK
                                                          : 8'(CH_ZERO + $urandom_range(9)));
                last_col = $urandom_range(1) ? SEP_LAST_COL - 1
                                             : $urandom_range(END_DIGIT_COL + 1,
                                                              SEP_LAST_COL - 1);
                for (int col = END_DIGIT_COL + 1; col <= last_col; col++)
                    q.insert(q.size(), is_sep_col(7'(col)) ? CH_BLANK : rand_seq_char());
                // trailing blanks, sometimes past the column limit
                if (last_col == SEP_LAST_COL - 1 && $urandom_range(2) == 0) begin
                    len = $urandom_range(1, 12);
                    repeat (len)
                        q.insert(q.size(),
                                 $urandom_range(4) == 0 ? rand_seq_char() : CH_BLANK);
                end
                if ($urandom_range(19) == 0)
                    q[END_DIGIT_COL] = CH_BLANK;
                if ($urandom_range(9) == 0)
                    q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            end else begin
                len = $urandom_range(1, 90);
                repeat (len) begin
                    pick = $urandom_range(9);
                    if (pick < 4)
                        q.insert(q.size(), 8'($urandom_range(255)));
                    else if (pick < 7)
                        q.insert(q.size(), CH_BLANK);
                    else
                        q.insert(q.size(), 8'(CH_ZERO + $urandom_range(9)));
                end
            end
            send_line(q, first || $urandom_range(99) < 8, 2);
            first = 1'b0;
            if ($urandom_range(29) == 0)
                hold_until_drained();
        end
        hold_until_drained();
    endtask

    // full-width lines with a fixed base mix
    task automatic test_long_lines();
        logic [CHAR_W-1:0] q [$];
        string             mix;
        int                k;
        mix  = "acgtN";
        k    = 0;
        flow = FLOW_STEADY;
        for (int n = 0; n < LONG_LINES; n++) begin
            q.delete();
            repeat (END_DIGIT_COL + 1) q.insert(q.size(), CH_ZERO);
            for (int col = END_DIGIT_COL + 1; col < SEP_LAST_COL; col++) begin
                if (is_sep_col(7'(col))) begin
                    q.insert(q.size(), CH_BLANK);
                end else begin
                    q.insert(q.size(), mix[k % 5]);
                    k++;
                end
            end
            send_line(q, n == 0, 0);
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.ch             = '0;
        in_ch.line_end       = 1'b0;
        in_ch.start_sequence = 1'b0;
        out_ch.ready         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random(FLOW_STEADY, 250, 1'b1);
        test_random(FLOW_SRC_GAPS, 220, 1'b0);
        test_random(FLOW_SINK_STALLS, 220, 1'b0);
        test_random(FLOW_BOTH, 220, 1'b0);
        test_long_lines();
        // restart the counts and finish under mixed stalls
        test_random(FLOW_BOTH, 80, 1'b1);

        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/slc_pkg.sv
hdl/slc_if.sv
hdl/slc_checker.sv
hdl/slc_counters.sv
hdl/sequence_line_checker_core.sv
dv/tb_top.sv
